// ----- design/slab_pkg.sv -----
`default_nettype none

package slab_pkg;

  // Width of the character count carried on every result.
  localparam int unsigned COUNT_W = 6;

  // Operation codes of an input item.
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Byte classes used by the receive filter.
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // One input item.
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_size;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]         char_out;
    logic               is_char;
    logic               line_given;
    logic [COUNT_W-1:0] char_count;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/slab_ram.sv -----
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module slab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/serial_line_assembly_buffer_core.sv -----
`default_nettype none

// Line assembly buffer for a serial receiver. On a receive item (opcode 0)
// printable bytes go into a ring of BUFFER_DEPTH entries (one kept free, so
// at most BUFFER_DEPTH-1 characters), CR and LF mark a line as ready when
// the ring is not empty, and everything else is dropped. A read item
// (opcode 1) gives one closing result when no line is ready. With a line
// ready it drains up to read_size-1 characters (no bound for a read_size of
// 0), one result each, then a closing result with the count. The character
// store is a memory with registered read data, and the drain sequencer
// waits for each read before it issues the next. No item is accepted while
// a read is being served.
module serial_line_assembly_buffer_core #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire slab_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output slab_pkg::out_item_t      out_item
);

  localparam int unsigned PW = $clog2(BUFFER_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(BUFFER_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_CLOSE
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic flag_r, flag_nxt;
  logic given_r, given_nxt;
  logic unlim_r, unlim_nxt;
  logic [7:0] limit_r, limit_nxt;
  logic [slab_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;
  slab_pkg::out_item_t out_item_r, out_item_nxt;

  logic in_acc;
  logic slot_free;
  logic is_eol;
  logic is_print;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] rp_inc;
  logic ram_we;
  logic ram_re;
  logic [7:0] ram_rdata;
  logic under_limit;

  // Handshake helpers.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Receive filter and ring pointer increments.
  assign is_eol   = (in_item.rx_byte == slab_pkg::CHAR_CR) ||
                    (in_item.rx_byte == slab_pkg::CHAR_LF);
  assign is_print = (in_item.rx_byte >= slab_pkg::PRINT_LO) &&
                    (in_item.rx_byte <= slab_pkg::PRINT_HI);
  assign wp_inc   = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
  assign rp_inc   = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;

  // Store a character when the ring has room. Writes happen only in the idle
  // state and reads only while draining, so the two never meet in a cycle.
  assign ram_we = in_acc && (in_item.opcode == slab_pkg::OP_RX) && !is_eol &&
                  is_print && (wp_inc != rp_r);
  assign under_limit = unlim_r || ({2'b00, count_r} < limit_r);
  assign ram_re = (state_r == S_CHECK) && (rp_r != wp_r) && under_limit;

  slab_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_item.rx_byte),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // Sequencer: next state, pointers and the output register.
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    flag_nxt      = flag_r;
    given_nxt     = given_r;
    unlim_nxt     = unlim_r;
    limit_nxt     = limit_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.opcode == slab_pkg::OP_READ) begin
            given_nxt = flag_r;
            count_nxt = '0;
            unlim_nxt = (in_item.read_size == 8'd0);
            limit_nxt = in_item.read_size - 8'd1;
            state_nxt = flag_r ? S_CHECK : S_CLOSE;
          end else if (is_eol) begin
            if (wp_r != rp_r) begin
              flag_nxt = 1'b1;
            end
          end else if (ram_we) begin
            wp_nxt = wp_inc;
          end
        end
      end
      S_CHECK: begin
        state_nxt = ram_re ? S_FETCH : S_CLOSE;
      end
      S_FETCH: begin
        // The character read in the previous cycle waits here for a free slot.
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.char_out   = ram_rdata;
          out_item_nxt.is_char    = 1'b1;
          out_item_nxt.line_given = 1'b1;
          out_item_nxt.char_count = count_r + 1'b1;
          out_item_nxt.last       = 1'b0;
          count_nxt               = count_r + 1'b1;
          rp_nxt                  = rp_inc;
          state_nxt               = S_CHECK;
        end
      end
      S_CLOSE: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.char_out   = 8'd0;
          out_item_nxt.is_char    = 1'b0;
          out_item_nxt.line_given = given_r;
          out_item_nxt.char_count = count_r;
          out_item_nxt.last       = 1'b1;
          flag_nxt                = 1'b0;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      flag_r      <= 1'b0;
      given_r     <= 1'b0;
      unlim_r     <= 1'b0;
      limit_r     <= 8'd0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      flag_r      <= flag_nxt;
      given_r     <= given_nxt;
      unlim_r     <= unlim_nxt;
      limit_r     <= limit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // A character result always belongs to a given line and never closes it.
  a_char_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_char |->
      out_item.line_given && !out_item.last && (out_item.char_count != '0))
    else $error("character result with bad flags or zero count");

  // A read is in flight only while the ring holds characters.
  a_fetch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> rp_r != wp_r)
    else $error("store read issued on an empty ring");

  // Both pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r <= LAST_IDX) && (rp_r <= LAST_IDX))
    else $error("ring pointer out of range");

  // A closing result without a line reports no characters.
  a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last && !out_item.line_given |->
      (out_item.char_count == '0) && !out_item.is_char)
    else $error("not-ready result carries data");

endmodule

`default_nettype wire
